// ===== hw/rtl/obt_pkg.sv =====
package obt_pkg;

    localparam int ANGLE_W       = 13;
    localparam int SIZE_W        = 14;
    localparam int TRIG_W        = 16;
    localparam int ANGLE_FULL    = 5760;
    localparam int ANGLE_QUARTER = 1440;
    // folded angle 0..ANGLE_QUARTER
    localparam int V_W           = 11;
    localparam int ONE_Q15       = 32767;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam int TAYLOR_TERMS  = 12;
    // c*w +- s*h and s*w +- c*h
    localparam int EDGE_W        = 31;
    // axis component times edge term, two of them summed
    localparam int PROJ_W        = 48;
    localparam int RAD_W         = 47;
    localparam int REACH_W       = 48;
    // projection scale 2 * ONE_Q15
    localparam int PROJ_SCALE    = 2 * ONE_Q15;

    // advance enables of four consecutive stages, lowest bit first
    typedef logic [3:0] stage_en_t;

endpackage

// ===== hw/rtl/oriented_box_overlap_test_top.sv =====
// Separating axis overlap test of two rotated rectangles. One pair of boxes is taken per
// clock while src_stall is low; hit is registered in the final stage. With no stall the
// rate is one item per cycle, held back only by stalls and set by the 8-stage
// pipeline: 4 stages of angle folding, table index numerator, reciprocal index divide and
// sine table read, then 4 stages of edge terms, axis projections, radius sums and the
// final compare. A stalled result holds only its own slot: empty stages upstream keep
// filling until the whole pipeline is full. hit is 1 when the boxes overlap or touch.
module oriented_box_overlap_test_top
    import obt_pkg::*;
#(
    parameter int SINE_TABLE_ENTRIES = 256,
    parameter int COORD_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         src_valid,
    output logic                         src_stall,
    input  logic signed [COORD_BITS-1:0] a_center_x,
    input  logic signed [COORD_BITS-1:0] a_center_y,
    input  logic [SIZE_W-1:0]            a_width,
    input  logic [SIZE_W-1:0]            a_height,
    input  logic [ANGLE_W-1:0]           a_angle,
    input  logic signed [COORD_BITS-1:0] b_center_x,
    input  logic signed [COORD_BITS-1:0] b_center_y,
    input  logic [SIZE_W-1:0]            b_width,
    input  logic [SIZE_W-1:0]            b_height,
    input  logic [ANGLE_W-1:0]           b_angle,
    output logic                         res_valid,
    input  logic                         res_stall,
    output logic                         hit
);

    localparam int DX_W = COORD_BITS + 1;

    logic [8:1] vld_reg;
    logic [8:1] vld_next;
    logic [9:1] adv;

    // a stage moves when it is empty or the one after it moves
    always_comb
    begin
        adv[9] = !res_stall;
        for (int k = 8; k >= 1; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next = {vld_reg[7:1], src_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 1; k <= 8; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    assign src_stall = !adv[1];
    assign res_valid = vld_reg[8];

    stage_en_t trig_en;
    stage_en_t sat_en;

    assign trig_en = adv[4:1];
    assign sat_en  = adv[8:5];

    logic signed [TRIG_W-1:0] sa;
    logic signed [TRIG_W-1:0] ca;
    logic signed [TRIG_W-1:0] sb;
    logic signed [TRIG_W-1:0] cb;

    obt_trig #(.SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES), .COSINE(1'b0)) u_sin_a
    (
        .clk   (clk),
        .en    (trig_en),
        .angle (a_angle),
        .value (sa)
    );

    obt_trig #(.SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES), .COSINE(1'b1)) u_cos_a
    (
        .clk   (clk),
        .en    (trig_en),
        .angle (a_angle),
        .value (ca)
    );

    obt_trig #(.SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES), .COSINE(1'b0)) u_sin_b
    (
        .clk   (clk),
        .en    (trig_en),
        .angle (b_angle),
        .value (sb)
    );

    obt_trig #(.SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES), .COSINE(1'b1)) u_cos_b
    (
        .clk   (clk),
        .en    (trig_en),
        .angle (b_angle),
        .value (cb)
    );

    // center offset and sizes ride alongside the trig lookup
    logic signed [DX_W-1:0] dx_next;
    logic signed [DX_W-1:0] dy_next;
    logic signed [DX_W-1:0] dx_reg [4];
    logic signed [DX_W-1:0] dy_reg [4];
    logic [SIZE_W-1:0]      aw_reg [4];
    logic [SIZE_W-1:0]      ah_reg [4];
    logic [SIZE_W-1:0]      bw_reg [4];
    logic [SIZE_W-1:0]      bh_reg [4];

    assign dx_next = DX_W'(b_center_x) - DX_W'(a_center_x);
    assign dy_next = DX_W'(b_center_y) - DX_W'(a_center_y);

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            dx_reg[0] <= dx_next;
            dy_reg[0] <= dy_next;
            aw_reg[0] <= a_width;
            ah_reg[0] <= a_height;
            bw_reg[0] <= b_width;
            bh_reg[0] <= b_height;
        end
        for (int k = 1; k < 4; k++)
        begin
            if (adv[k+1])
            begin
                dx_reg[k] <= dx_reg[k-1];
                dy_reg[k] <= dy_reg[k-1];
                aw_reg[k] <= aw_reg[k-1];
                ah_reg[k] <= ah_reg[k-1];
                bw_reg[k] <= bw_reg[k-1];
                bh_reg[k] <= bh_reg[k-1];
            end
        end
    end

    obt_sat #(.COORD_BITS(COORD_BITS)) u_sat
    (
        .clk (clk),
        .en  (sat_en),
        .sa  (sa),
        .ca  (ca),
        .sb  (sb),
        .cb  (cb),
        .aw  (aw_reg[3]),
        .ah  (ah_reg[3]),
        .bw  (bw_reg[3]),
        .bh  (bh_reg[3]),
        .dx  (dx_reg[3]),
        .dy  (dy_reg[3]),
        .hit (hit)
    );

`ifndef SYNTH
    // input is held back only when every stage is occupied and the output is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |-> (&vld_reg) && res_stall)
        else $error("input stalled while the pipeline has a free slot");

    assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && !src_stall |=> vld_reg[1])
        else $error("accepted transfer not captured in the first stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall && !vld_reg[7] |=> !res_valid)
        else $error("result repeated after its transfer");
`endif

endmodule

// ===== hw/rtl/obt_trig.sv =====
module obt_trig
    import obt_pkg::*;
#(
    parameter int SINE_TABLE_ENTRIES = 256,
    parameter bit COSINE = 1'b0
)
(
    input  logic                     clk,
    input  stage_en_t                en,
    input  logic [ANGLE_W-1:0]       angle,
    output logic signed [TRIG_W-1:0] value
);

    localparam longint unsigned NUM_MAX =
        longint'(ANGLE_QUARTER) * longint'(SINE_TABLE_ENTRIES) + longint'(ANGLE_QUARTER / 2);
    localparam int NUM_W  = $clog2(NUM_MAX + 1);
    localparam int SHIFT  = NUM_W + 11;
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + longint'(ANGLE_QUARTER - 1)) / longint'(ANGLE_QUARTER);
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PROD_W  = NUM_W + RECIP_W;
    localparam int IDX_W   = $clog2(SINE_TABLE_ENTRIES + 1);

    function automatic logic [TRIG_W-2:0] sine_entry(input int unsigned k);
        logic [63:0]        x;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] sum;
        x = (64'(k) * HALF_PI_Q30) / 64'(SINE_TABLE_ENTRIES);
        term = x;
        sum = $signed(x);
        for (int i = 1; i < TAYLOR_TERMS; i++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * i) * (2 * i + 1));
            if (i % 2 == 1)
            begin
                sum = sum - $signed(term);
            end
            else
            begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        v = (64'(sum) * 64'(ONE_Q15) + (64'd1 << 29)) >> 30;
        if (v > 64'(ONE_Q15))
        begin
            v = 64'(ONE_Q15);
        end
        return v[TRIG_W-2:0];
    endfunction

    logic [TRIG_W-2:0] sine_rom [SINE_TABLE_ENTRIES+1];

    for (genvar k = 0; k <= SINE_TABLE_ENTRIES; k++)
    begin : g_rom
        assign sine_rom[k] = sine_entry(k);
    end

    // stage 1: wrap, quadrant, fold into the first quarter
    logic [ANGLE_W:0]   sum_a;
    logic [ANGLE_W:0]   wrap_a;
    logic [1:0]         quad;
    logic [V_W-1:0]     rem;
    logic [V_W-1:0]     fold_next;
    logic               neg_next;
    logic [V_W-1:0]     fold_reg;
    logic               neg_reg;

    always_comb
    begin
        sum_a = {1'b0, angle} + (COSINE ? (ANGLE_W+1)'(ANGLE_QUARTER) : '0);
        if (sum_a >= (ANGLE_W+1)'(ANGLE_FULL))
        begin
            wrap_a = sum_a - (ANGLE_W+1)'(ANGLE_FULL);
        end
        else
        begin
            wrap_a = sum_a;
        end
        if (wrap_a >= (ANGLE_W+1)'(3 * ANGLE_QUARTER))
        begin
            quad = 2'd3;
            rem  = V_W'(wrap_a - (ANGLE_W+1)'(3 * ANGLE_QUARTER));
        end
        else if (wrap_a >= (ANGLE_W+1)'(2 * ANGLE_QUARTER))
        begin
            quad = 2'd2;
            rem  = V_W'(wrap_a - (ANGLE_W+1)'(2 * ANGLE_QUARTER));
        end
        else if (wrap_a >= (ANGLE_W+1)'(ANGLE_QUARTER))
        begin
            quad = 2'd1;
            rem  = V_W'(wrap_a - (ANGLE_W+1)'(ANGLE_QUARTER));
        end
        else
        begin
            quad = 2'd0;
            rem  = V_W'(wrap_a);
        end
        fold_next = quad[0] ? (V_W'(ANGLE_QUARTER) - rem) : rem;
        neg_next  = quad[1];
    end

    // stage 2: scaled numerator for the table index
    logic [NUM_W-1:0] num_next;
    logic [NUM_W-1:0] num_reg;
    logic             neg2_reg;

    assign num_next = NUM_W'(fold_reg) * NUM_W'(SINE_TABLE_ENTRIES)
                    + NUM_W'(ANGLE_QUARTER / 2);

    // stage 3: divide by a quarter turn through an exact reciprocal
    logic [PROD_W-1:0] prod;
    logic [IDX_W-1:0]  idx_next;
    logic [IDX_W-1:0]  idx_reg;
    logic              neg3_reg;

    assign prod     = PROD_W'(num_reg) * PROD_W'(RECIP);
    assign idx_next = prod[SHIFT +: IDX_W];

    // stage 4: table read and sign
    logic signed [TRIG_W-1:0] value_next;
    logic signed [TRIG_W-1:0] value_reg;

    always_comb
    begin
        value_next = $signed({1'b0, sine_rom[idx_reg]});
        if (neg3_reg)
        begin
            value_next = -value_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            fold_reg <= fold_next;
            neg_reg  <= neg_next;
        end
        if (en[1])
        begin
            num_reg  <= num_next;
            neg2_reg <= neg_reg;
        end
        if (en[2])
        begin
            idx_reg  <= idx_next;
            neg3_reg <= neg2_reg;
        end
        if (en[3])
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

// ===== hw/rtl/obt_sat.sv =====
module obt_sat
    import obt_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                      clk,
    input  stage_en_t                 en,
    input  logic signed [TRIG_W-1:0]  sa,
    input  logic signed [TRIG_W-1:0]  ca,
    input  logic signed [TRIG_W-1:0]  sb,
    input  logic signed [TRIG_W-1:0]  cb,
    input  logic [SIZE_W-1:0]         aw,
    input  logic [SIZE_W-1:0]         ah,
    input  logic [SIZE_W-1:0]         bw,
    input  logic [SIZE_W-1:0]         bh,
    input  logic signed [COORD_BITS:0] dx,
    input  logic signed [COORD_BITS:0] dy,
    output logic                      hit
);

    localparam int DX_W  = COORD_BITS + 1;
    localparam int U_W   = COORD_BITS + 18;
    localparam int UA_W  = COORD_BITS + 17;
    localparam int CMP_W = (COORD_BITS + 33 > REACH_W) ? COORD_BITS + 33 : REACH_W;

    // stage 5: rotated half-diagonal terms of both boxes
    logic signed [EDGE_W-1:0] edge_next [8];
    logic signed [EDGE_W-1:0] edge_reg  [8];
    logic signed [TRIG_W-1:0] trig_reg  [4];
    logic signed [DX_W-1:0]   dx_reg;
    logic signed [DX_W-1:0]   dy_reg;

    function automatic logic signed [EDGE_W-1:0] mul_cs(input logic signed [TRIG_W-1:0] t,
                                                        input logic [SIZE_W-1:0] s);
        return EDGE_W'(t) * $signed(EDGE_W'(s));
    endfunction

    always_comb
    begin
        edge_next[0] = mul_cs(ca, aw) - mul_cs(sa, ah);
        edge_next[1] = mul_cs(sa, aw) + mul_cs(ca, ah);
        edge_next[2] = mul_cs(ca, aw) + mul_cs(sa, ah);
        edge_next[3] = mul_cs(sa, aw) - mul_cs(ca, ah);
        edge_next[4] = mul_cs(cb, bw) - mul_cs(sb, bh);
        edge_next[5] = mul_cs(sb, bw) + mul_cs(cb, bh);
        edge_next[6] = mul_cs(cb, bw) + mul_cs(sb, bh);
        edge_next[7] = mul_cs(sb, bw) - mul_cs(cb, bh);
    end

    // stage 6: corner and center projections on the four axes
    logic signed [TRIG_W-1:0] ux [4];
    logic signed [TRIG_W-1:0] uy [4];
    logic signed [PROJ_W-1:0] proj_next [16];
    logic signed [PROJ_W-1:0] proj_reg  [16];
    logic signed [U_W-1:0]    ctr_next  [4];
    logic signed [U_W-1:0]    ctr_reg   [4];

    always_comb
    begin
        ux[0] = trig_reg[1];  uy[0] = trig_reg[0];
        ux[1] = -trig_reg[0]; uy[1] = trig_reg[1];
        ux[2] = trig_reg[3];  uy[2] = trig_reg[2];
        ux[3] = -trig_reg[2]; uy[3] = trig_reg[3];
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                // j selects box (high bit) and corner pair (low bit)
                proj_next[i*4+j] = PROJ_W'(ux[i]) * PROJ_W'(edge_reg[j*2])
                                 + PROJ_W'(uy[i]) * PROJ_W'(edge_reg[j*2+1]);
            end
            ctr_next[i] = U_W'(ux[i]) * U_W'(dx_reg) + U_W'(uy[i]) * U_W'(dy_reg);
        end
    end

    // stage 7: box radii summed, center distance magnitude
    logic [RAD_W-1:0]   mag      [16];
    logic [RAD_W-1:0]   rad      [8];
    logic [REACH_W-1:0] reach_next [4];
    logic [REACH_W-1:0] reach_reg  [4];
    logic [UA_W-1:0]    dist_next  [4];
    logic [UA_W-1:0]    dist_reg   [4];

    always_comb
    begin
        for (int j = 0; j < 16; j++)
        begin
            mag[j] = proj_reg[j] < 0 ? RAD_W'(-proj_reg[j]) : RAD_W'(proj_reg[j]);
        end
        for (int j = 0; j < 8; j++)
        begin
            rad[j] = mag[j*2] > mag[j*2+1] ? mag[j*2] : mag[j*2+1];
        end
        for (int i = 0; i < 4; i++)
        begin
            reach_next[i] = REACH_W'(rad[i*2]) + REACH_W'(rad[i*2+1]);
            dist_next[i]  = ctr_reg[i] < 0 ? UA_W'(-ctr_reg[i]) : UA_W'(ctr_reg[i]);
        end
    end

    // stage 8: separated when dist * 2 * 32767 exceeds the reach
    logic [CMP_W-1:0] lhs [4];
    logic [3:0]       sep;
    logic             hit_next;
    logic             hit_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            lhs[i] = CMP_W'(dist_reg[i]) * CMP_W'(PROJ_SCALE);
            sep[i] = lhs[i] > CMP_W'(reach_reg[i]);
        end
        hit_next = ~|sep;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            edge_reg    <= edge_next;
            trig_reg[0] <= sa;
            trig_reg[1] <= ca;
            trig_reg[2] <= sb;
            trig_reg[3] <= cb;
            dx_reg      <= dx;
            dy_reg      <= dy;
        end
        if (en[1])
        begin
            proj_reg <= proj_next;
            ctr_reg  <= ctr_next;
        end
        if (en[2])
        begin
            reach_reg <= reach_next;
            dist_reg  <= dist_next;
        end
        if (en[3])
        begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

// ===== dv/oriented_box_overlap_test_top_test.sv =====
module oriented_box_overlap_test_top_test;
    import obt_pkg::*;

    localparam int TABLE_STEPS = 256;
    localparam int CW = 16;
    localparam int IDLE_LIMIT = 2000;

    typedef struct {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic [SIZE_W-1:0]    w;
        logic [SIZE_W-1:0]    h;
        logic [ANGLE_W-1:0]   ang;
    } box_t;

    logic clk;
    logic rst_n;
    logic src_valid;
    logic src_stall;
    logic signed [CW-1:0] a_center_x, a_center_y, b_center_x, b_center_y;
    logic [SIZE_W-1:0] a_width, a_height, b_width, b_height;
    logic [ANGLE_W-1:0] a_angle, b_angle;
    logic res_valid;
    logic res_stall;
    logic hit;

    longint quarter_sine[0:TABLE_STEPS];
    bit expected_hits[$];
    int errors = 0;
    int transfers_in = 0;
    int transfers_out = 0;
    int hits_seen = 0;
    int idle_cycles = 0;
    bit stall_noise = 1;
    bit send_noise = 1;

    oriented_box_overlap_test_top dut (
        .clk(clk), .rst_n(rst_n),
        .src_valid(src_valid), .src_stall(src_stall),
        .a_center_x(a_center_x), .a_center_y(a_center_y),
        .a_width(a_width), .a_height(a_height), .a_angle(a_angle),
        .b_center_x(b_center_x), .b_center_y(b_center_y),
        .b_width(b_width), .b_height(b_height), .b_angle(b_angle),
        .res_valid(res_valid), .res_stall(res_stall), .hit(hit)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // taylor series in Q30, rounded to Q1.15
    function automatic longint taylor_sine(longint unsigned k);
        longint unsigned x, term, v;
        longint sum;
        x = (k * HALF_PI_Q30) / TABLE_STEPS;
        term = x;
        sum = x;
        for (int i = 1; i < TAYLOR_TERMS; i++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / ((2 * i) * (2 * i + 1));
            if (i % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        v = (longint'(sum) * ONE_Q15 + (64'd1 << 29)) >> 30;
        if (v > ONE_Q15)
            v = ONE_Q15;
        return longint'(v);
    endfunction

    function automatic longint trig(longint unsigned a);
        longint unsigned q, r, v;
        longint m;
        a = a % ANGLE_FULL;
        q = a / ANGLE_QUARTER;
        r = a % ANGLE_QUARTER;
        v = (q % 2 == 1) ? ANGLE_QUARTER - r : r;
        m = quarter_sine[(v * TABLE_STEPS + ANGLE_QUARTER / 2) / ANGLE_QUARTER];
        return (q >= 2) ? -m : m;
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint half_extent(longint c, longint s, longint w, longint h,
                                           longint ux, longint uy);
        longint p1, p2;
        p1 = mag(ux * (c * w - s * h) + uy * (s * w + c * h));
        p2 = mag(ux * (c * w + s * h) + uy * (s * w - c * h));
        return p1 > p2 ? p1 : p2;
    endfunction

    function automatic bit boxes_overlap(box_t a, box_t b);
        longint sa, ca, sb, cb, dx, dy, ux, uy, proj, reach;
        longint axes[4][2];
        sa = trig(a.ang);
        ca = trig(a.ang + ANGLE_QUARTER);
        sb = trig(b.ang);
        cb = trig(b.ang + ANGLE_QUARTER);
        dx = longint'(b.cx) - longint'(a.cx);
        dy = longint'(b.cy) - longint'(a.cy);
        axes[0][0] = ca;  axes[0][1] = sa;
        axes[1][0] = -sa; axes[1][1] = ca;
        axes[2][0] = cb;  axes[2][1] = sb;
        axes[3][0] = -sb; axes[3][1] = cb;
        for (int i = 0; i < 4; i++)
        begin
            ux = axes[i][0];
            uy = axes[i][1];
            proj = mag(ux * dx + uy * dy);
            reach = half_extent(ca, sa, a.w, a.h, ux, uy)
                  + half_extent(cb, sb, b.w, b.h, ux, uy);
            if (proj > reach / PROJ_SCALE)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic box_t mk(int cx, int cy, int w, int h, int ang);
        box_t r;
        r.cx = CW'(cx);
        r.cy = CW'(cy);
        r.w = SIZE_W'(w);
        r.h = SIZE_W'(h);
        r.ang = ANGLE_W'(ang);
        return r;
    endfunction

    function automatic box_t rand_box(int span, int size_max);
        box_t r;
        r.cx = CW'($urandom_range(2 * span) - span);
        r.cy = CW'($urandom_range(2 * span) - span);
        r.w = SIZE_W'($urandom_range(size_max));
        r.h = SIZE_W'($urandom_range(size_max));
        r.ang = ANGLE_W'($urandom_range(8191));
        return r;
    endfunction

    task automatic send_pair(box_t a, box_t b);
        if (send_noise && $urandom_range(7) == 0)
        begin
            src_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        src_valid <= 1'b1;
        a_center_x <= a.cx; a_center_y <= a.cy;
        a_width <= a.w; a_height <= a.h; a_angle <= a.ang;
        b_center_x <= b.cx; b_center_y <= b.cy;
        b_width <= b.w; b_height <= b.h; b_angle <= b.ang;
        expected_hits = {expected_hits, boxes_overlap(a, b)};
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        transfers_in++;
        @(negedge clk);
    endtask

    task automatic pause_sender();
        src_valid <= 1'b0;
        while (expected_hits.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_extremes();
        send_pair(mk(0, 0, 0, 0, 0), mk(0, 0, 0, 0, 0));
        send_pair(mk(0, 0, 0, 0, 0), mk(1, 0, 0, 0, 0));
        send_pair(mk(-32768, -32768, 16383, 16383, 0), mk(32767, 32767, 16383, 16383, 5759));
        send_pair(mk(-32768, 32767, 16383, 0, 8191), mk(32767, -32768, 0, 16383, 5760));
        send_pair(mk(0, 0, 16383, 16383, 720), mk(-32768, 0, 16383, 16383, 8191));
        send_pair(mk(0, 0, 32, 32, 0), mk(32, 0, 32, 32, 0));
        send_pair(mk(0, 0, 32, 32, 0), mk(33, 0, 32, 32, 0));
        send_pair(mk(0, 0, 32, 32, 1440), mk(0, 32, 32, 32, 2880));
        send_pair(mk(0, 0, 100, 0, 4320), mk(0, 50, 0, 100, 1440));
        send_pair(mk(100, 100, 200, 40, 720), mk(160, 160, 200, 40, 6480));
        send_pair(mk(0, 0, 160, 160, 720), mk(115, 0, 16, 16, 0));
        send_pair(mk(0, 0, 160, 160, 720), mk(125, 0, 16, 16, 0));
        send_pair(mk(-5, 7, 1, 1, 5000), mk(-5, 7, 1, 1, 3000));
        send_pair(mk(21845, -10923, 10922, 5461, 4095), mk(-21846, 10922, 5461, 10922, 2730));
        pause_sender();
    endtask

    task automatic test_random(int n, int span, int size_max);
        box_t a, b;
        for (int i = 0; i < n; i++)
        begin
            a = rand_box(span, size_max);
            b = ($urandom_range(3) == 0) ? rand_box(32768, 16383) : rand_box(span, size_max);
            send_pair(a, b);
        end
    endtask

    task automatic test_near_boxes(int n);
        box_t a, b;
        for (int i = 0; i < n; i++)
        begin
            a = rand_box(2000, 800);
            b = a;
            b.cx = CW'(int'(a.cx) + int'($urandom_range(1600)) - 800);
            b.cy = CW'(int'(a.cy) + int'($urandom_range(1600)) - 800);
            b.w = SIZE_W'($urandom_range(800));
            b.h = SIZE_W'($urandom_range(800));
            b.ang = ANGLE_W'($urandom_range(8191));
            send_pair(a, b);
        end
    endtask

    initial
    begin
        for (int k = 0; k <= TABLE_STEPS; k++)
            quarter_sine[k] = taylor_sine(k);
        rst_n = 1'b0;
        src_valid = 1'b0;
        res_stall = 1'b0;
        a_center_x = '0; a_center_y = '0; a_width = '0; a_height = '0; a_angle = '0;
        b_center_x = '0; b_center_y = '0; b_width = '0; b_height = '0; b_angle = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_extremes();
        test_random(200, 32768, 16383);
        test_near_boxes(350);
        pause_sender();
        send_noise = 0;
        stall_noise = 0;
        test_near_boxes(150);
        test_random(100, 4000, 3000);
        src_valid <= 1'b0;
        while (expected_hits.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        $display("covered %0d box pairs, %0d overlapping, with random sender gaps and stalls",
                 transfers_in, hits_seen);
        if (errors == 0 && transfers_out == transfers_in)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // result stall in bursts
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_noise && $urandom_range(5) == 0)
            begin
                gap = $urandom_range(1, 17);
                res_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            res_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        bit want;
        if (rst_n && res_valid && !res_stall)
        begin
            transfers_out++;
            if (expected_hits.size() == 0)
            begin
                errors++;
                $error("hit transfer with nothing expected, actual %0b", hit);
            end
            else
            begin
                want = expected_hits.pop_front();
                if (hit !== want)
                begin
                    errors++;
                    $error("hit mismatch: expected %0b actual %0b", want, hit);
                end
                if (hit === 1'b1)
                    hits_seen++;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((src_valid && !src_stall) || (res_valid && !res_stall) || !rst_n)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

endmodule
